/* rtl/source_text_tokenizer_macros.svh */
// assertion macros for the source text tokenizer checker
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequent checked in the same cycle
`define STT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Types, token codes and lookup functions shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } char_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] line_no;
    logic [23:0] start_pos;
    logic [7:0]  lexeme_len;
    logic [30:0] whole_value;
    logic [30:0] frac_value;
    logic [7:0]  frac_digits;
    logic        is_real;
    logic        overflow;
    logic        last_token;
  } token_t;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_OP      = 3'd1;
  localparam logic [2:0] M_IDENT   = 3'd2;
  localparam logic [2:0] M_WHOLE   = 3'd3;
  localparam logic [2:0] M_FRAC    = 3'd4;
  localparam logic [2:0] M_COMMENT = 3'd5;

  localparam logic [5:0] K_IDENT  = 6'd0;
  localparam logic [5:0] K_NUMBER = 6'd1;
  localparam logic [5:0] K_NONE   = 6'd0;
  localparam logic [5:0] K_EOF    = 6'd39;
  localparam logic [5:0] K_ERROR  = 6'd40;

  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "*": k = 6'd2;
      "(": k = 6'd3;
      ")": k = 6'd4;
      "{": k = 6'd5;
      "}": k = 6'd6;
      ",": k = 6'd7;
      ".": k = 6'd8;
      "-": k = 6'd9;
      "+": k = 6'd10;
      ";": k = 6'd11;
      "!": k = 6'd13;
      "<": k = 6'd15;
      ">": k = 6'd17;
      "/": k = 6'd18;
      "=": k = 6'd20;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c == 8'd9) || (c == 8'd11) || (c == 8'd12) || (c == 8'd13);
  endfunction

  // prefix holds the first byte in its low bits, so literals are byte reversed
  function automatic logic [5:0] ident_kind(input logic [55:0] kp, input logic [7:0] tl);
    logic [5:0] k;
    k = K_IDENT;
    if      (tl == 8'd3 && kp == 56'("dna"))    k = 6'd21;
    else if (tl == 8'd5 && kp == 56'("ssalc"))  k = 6'd22;
    else if (tl == 8'd3 && kp == 56'("fed"))    k = 6'd23;
    else if (tl == 8'd4 && kp == 56'("esle"))   k = 6'd24;
    else if (tl == 8'd6 && kp == 56'("nretxe")) k = 6'd25;
    else if (tl == 8'd5 && kp == 56'("eslaf"))  k = 6'd26;
    else if (tl == 8'd3 && kp == 56'("rof"))    k = 6'd27;
    else if (tl == 8'd3 && kp == 56'("nuf"))    k = 6'd28;
    else if (tl == 8'd2 && kp == 56'("fi"))     k = 6'd29;
    else if (tl == 8'd3 && kp == 56'("lin"))    k = 6'd30;
    else if (tl == 8'd2 && kp == 56'("ro"))     k = 6'd31;
    else if (tl == 8'd5 && kp == 56'("tnirp"))  k = 6'd32;
    else if (tl == 8'd6 && kp == 56'("nruter")) k = 6'd33;
    else if (tl == 8'd5 && kp == 56'("repus"))  k = 6'd34;
    else if (tl == 8'd4 && kp == 56'("siht"))   k = 6'd35;
    else if (tl == 8'd4 && kp == 56'("eurt"))   k = 6'd36;
    else if (tl == 8'd3 && kp == 56'("rav"))    k = 6'd37;
    else if (tl == 8'd5 && kp == 56'("elihw"))  k = 6'd38;
    return k;
  endfunction

  // acc * 10 + d, saturating; top bit flags saturation
  function automatic logic [31:0] acc_digit(input logic [30:0] acc, input logic [3:0] d);
    logic [34:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, d};
    if (v > {4'b0, SAT31}) return {1'b1, SAT31};
    return {1'b0, v[30:0]};
  endfunction

endpackage

`default_nettype wire

/* rtl/stt_scan.sv */
// ----------------------------------------------------------------------------
// stt_scan
// Scanner state and one-byte step: updates state and forms up to three tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_scan #(
  parameter int POS_BITS  = 24,
  parameter int LINE_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire stt_pkg::char_t  src,
  output stt_pkg::token_t      res [3],
  output logic [2:0]           res_valid
);
  import stt_pkg::*;

  logic [2:0]           scan_mode, scan_mode_next;
  logic [7:0]           pending_op, pending_op_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;
  logic [POS_BITS-1:0]  position, position_next;
  logic [POS_BITS-1:0]  token_start, token_start_next;
  logic [7:0]           token_length, token_length_next;
  logic [55:0]          keyword_prefix, keyword_prefix_next;
  logic [30:0]          whole_acc, whole_acc_next;
  logic [30:0]          frac_acc, frac_acc_next;
  logic [7:0]           frac_count, frac_count_next;
  logic                 overflow_seen, overflow_seen_next;

  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  function automatic token_t mk(input logic [5:0] kind, input logic [LINE_BITS-1:0] lc,
                                input logic [POS_BITS-1:0] st, input logic [7:0] len,
                                input logic num, input logic real_f, input logic last,
                                input logic [30:0] wa, input logic [30:0] fa,
                                input logic [7:0] fc, input logic ov);
    token_t t;
    t.token_kind  = kind;
    t.line_no     = 16'(lc);
    t.start_pos   = 24'(st);
    t.lexeme_len  = len;
    t.whole_value = num ? wa : '0;
    t.frac_value  = num ? fa : '0;
    t.frac_digits = num ? fc : '0;
    t.is_real     = num & real_f;
    t.overflow    = num & ov;
    t.last_token  = last;
    return t;
  endfunction

  logic [7:0]          c;
  logic [31:0]         acc;
  logic [1:0]          n;
  logic                used;
  logic                fl_v;
  token_t              r [3];
  logic [2:0]          rv;

  always_comb begin
    scan_mode_next      = scan_mode;
    pending_op_next     = pending_op;
    line_count_next     = line_count;
    token_start_next    = token_start;
    token_length_next   = token_length;
    keyword_prefix_next = keyword_prefix;
    whole_acc_next      = whole_acc;
    frac_acc_next       = frac_acc;
    frac_count_next     = frac_count;
    overflow_seen_next  = overflow_seen;
    c    = src.char_in;
    acc  = '0;
    n    = 2'd0;
    used = 1'b0;
    rv   = 3'b000;
    fl_v = 1'b0;
    for (int i = 0; i < 3; i++) r[i] = '0;

    // first part: continue the token in progress
    case (scan_mode)
      M_OP: begin
        if (c == "=" && pending_op != "/") begin
          r[n] = mk(single_kind(pending_op) - 6'd1, line_count_next, token_start_next,
                    8'd2, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
          rv[n] = 1'b1; n = n + 2'd1;
          scan_mode_next = M_IDLE;
          used = 1'b1;
        end else if (c == "/" && pending_op == "/") begin
          scan_mode_next = M_COMMENT;
          used = 1'b1;
        end else begin
          fl_v = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (token_length < 8'd7) keyword_prefix_next[8*token_length[2:0] +: 8] = c;
          if (token_length != 8'hFF) token_length_next = token_length + 8'd1;
          used = 1'b1;
        end else begin
          fl_v = 1'b1;
        end
      end
      M_WHOLE: begin
        if (is_digit(c)) begin
          acc = acc_digit(whole_acc, 4'(c - "0"));
          whole_acc_next = acc[30:0];
          if (acc[31]) overflow_seen_next = 1'b1;
          if (token_length != 8'hFF) token_length_next = token_length + 8'd1;
          used = 1'b1;
        end else if (c == ".") begin
          scan_mode_next = M_FRAC;
          if (token_length != 8'hFF) token_length_next = token_length + 8'd1;
          used = 1'b1;
        end else begin
          fl_v = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_digit(c)) begin
          acc = acc_digit(frac_acc, 4'(c - "0"));
          frac_acc_next = acc[30:0];
          if (acc[31]) overflow_seen_next = 1'b1;
          if (frac_count != 8'hFF) frac_count_next = frac_count + 8'd1;
          if (token_length != 8'hFF) token_length_next = token_length + 8'd1;
          used = 1'b1;
        end else begin
          fl_v = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == 8'd10) begin
          if (line_count != LINE_MAX) line_count_next = line_count + 1'b1;
          scan_mode_next = M_IDLE;
        end
        used = 1'b1;
      end
      default: scan_mode_next = M_IDLE;
    endcase

    if (fl_v) begin
      case (scan_mode)
        M_OP:    r[n] = mk(single_kind(pending_op), line_count_next, token_start, 8'd1,
                           1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        M_IDENT: r[n] = mk(ident_kind(keyword_prefix, token_length), line_count_next,
                           token_start, token_length, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
        default: r[n] = mk(K_NUMBER, line_count_next, token_start, token_length, 1'b1,
                           scan_mode == M_FRAC, 1'b0, whole_acc, frac_acc, frac_count,
                           overflow_seen);
      endcase
      rv[n] = 1'b1; n = n + 2'd1;
      scan_mode_next = M_IDLE;
    end

    // second part: this byte starts something new
    if (!used) begin
      token_start_next  = position;
      token_length_next = 8'd1;
      if (c == "!" || c == "<" || c == ">" || c == "=" || c == "/") begin
        pending_op_next = c;
        scan_mode_next  = M_OP;
      end else if (single_kind(c) != K_NONE) begin
        r[n] = mk(single_kind(c), line_count_next, position, 8'd1, 1'b0, 1'b0, 1'b0,
                  '0, '0, '0, 1'b0);
        rv[n] = 1'b1; n = n + 2'd1;
      end else if (is_digit(c)) begin
        whole_acc_next     = 31'(c - "0");
        frac_acc_next      = '0;
        frac_count_next    = '0;
        overflow_seen_next = 1'b0;
        scan_mode_next     = M_WHOLE;
      end else if (is_alpha(c)) begin
        keyword_prefix_next = 56'(c);
        scan_mode_next      = M_IDENT;
      end else if (c == 8'd10) begin
        if (line_count_next != LINE_MAX) line_count_next = line_count_next + 1'b1;
      end else if (!is_space(c)) begin
        r[n] = mk(K_ERROR, line_count_next, position, 8'd1, 1'b0, 1'b0, 1'b0,
                  '0, '0, '0, 1'b0);
        rv[n] = 1'b1; n = n + 2'd1;
      end
    end
    position_next = position + 1'b1;

    // last byte: flush what is pending, then the end marker
    if (src.end_of_text) begin
      if (scan_mode_next == M_OP || scan_mode_next == M_IDENT ||
          scan_mode_next == M_WHOLE || scan_mode_next == M_FRAC) begin
        case (scan_mode_next)
          M_OP:    r[n] = mk(single_kind(pending_op_next), line_count_next,
                             token_start_next, 8'd1, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
          M_IDENT: r[n] = mk(ident_kind(keyword_prefix_next, token_length_next),
                             line_count_next, token_start_next, token_length_next,
                             1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
          default: r[n] = mk(K_NUMBER, line_count_next, token_start_next, token_length_next,
                             1'b1, scan_mode_next == M_FRAC, 1'b0, whole_acc_next,
                             frac_acc_next, frac_count_next, overflow_seen_next);
        endcase
        rv[n] = 1'b1; n = n + 2'd1;
      end
      r[n] = mk(K_EOF, line_count_next, position_next, 8'd0, 1'b0, 1'b0, 1'b1,
                '0, '0, '0, 1'b0);
      rv[n] = 1'b1;
      line_count_next = '0;
      position_next   = '0;
      scan_mode_next  = M_IDLE;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) res[i] = r[i];
    res_valid = step ? rv : 3'b000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= M_IDLE;
      pending_op     <= '0;
      line_count     <= '0;
      position       <= '0;
      token_start    <= '0;
      token_length   <= '0;
      keyword_prefix <= '0;
      whole_acc      <= '0;
      frac_acc       <= '0;
      frac_count     <= '0;
      overflow_seen  <= 1'b0;
    end else if (step) begin
      scan_mode      <= scan_mode_next;
      pending_op     <= pending_op_next;
      line_count     <= line_count_next;
      position       <= position_next;
      token_start    <= token_start_next;
      token_length   <= token_length_next;
      keyword_prefix <= keyword_prefix_next;
      whole_acc      <= whole_acc_next;
      frac_acc       <= frac_acc_next;
      frac_count     <= frac_count_next;
      overflow_seen  <= overflow_seen_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/stt_queue.sv */
// ----------------------------------------------------------------------------
// stt_queue
// Eight-entry token queue: up to three tokens in, one out per cycle if ready.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire stt_pkg::token_t wr_data [3],
  input  wire logic [2:0]      wr_valid,
  output logic                 room,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output stt_pkg::token_t      rd_data
);
  import stt_pkg::*;

  token_t     mem [8];
  logic [2:0] wr_ptr;
  logic [2:0] rd_ptr;
  logic [3:0] count;
  logic [1:0] n_wr;
  logic       pop;
  logic [2:0] slot [3];

  // valid bits are packed from the bottom, so the count is the highest set bit
  always_comb begin
    n_wr = wr_valid[2] ? 2'd3 : wr_valid[1] ? 2'd2 : wr_valid[0] ? 2'd1 : 2'd0;
    for (int i = 0; i < 3; i++) slot[i] = wr_ptr + 3'(i);
  end

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = count != 4'd0;
  assign rd_data  = mem[rd_ptr];
  assign room     = count <= 4'd5;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (wr_valid[i]) mem[slot[i]] <= wr_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + 3'(n_wr);
      if (pop) rd_ptr <= rd_ptr + 3'd1;
      count <= count + 4'(n_wr) - 4'(pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/source_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming scanner turning source bytes into tokens.
// ----------------------------------------------------------------------------
// One byte is taken per clock; each byte yields zero to three tokens in the
// same cycle, and these are held in an eight-entry queue that drains one token
// per clock. The input is ready whenever the queue has room for three tokens,
// so the sustained rate is one byte a cycle until token output backs up; the
// single output port then sets the pace. A byte marked as end of text flushes
// any pending token, adds an EOF token and restarts line and offset counting.
`default_nettype none

module source_text_tokenizer #(
  parameter int POS_BITS  = 24,
  parameter int LINE_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            src_valid,
  output logic                 src_ready,
  input  wire stt_pkg::char_t  src,
  output logic                 tok_valid,
  input  wire logic            tok_ready,
  output stt_pkg::token_t      tok
);
  import stt_pkg::*;

  token_t     res [3];
  logic [2:0] res_valid;
  logic       room;

  assign src_ready = room;

  stt_scan #(.POS_BITS(POS_BITS), .LINE_BITS(LINE_BITS)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (src_valid && src_ready),
    .src       (src),
    .res       (res),
    .res_valid (res_valid)
  );

  stt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (res),
    .wr_valid (res_valid),
    .room     (room),
    .rd_valid (tok_valid),
    .rd_ready (tok_ready),
    .rd_data  (tok)
  );

endmodule

`default_nettype wire

/* rtl/stt_checker.sv */
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "source_text_tokenizer_macros.svh"

module stt_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            src_valid,
  input wire logic            src_ready,
  input wire logic            tok_valid,
  input wire logic            tok_ready,
  input wire stt_pkg::token_t tok
);
  import stt_pkg::*;

  logic src_fire;
  logic tok_stall;
  logic tok_last;
  logic eof_ok;
  logic non_num;
  logic num_zero;

  assign src_fire  = src_valid && src_ready;
  assign tok_stall = tok_valid && !tok_ready;
  assign tok_last  = tok_valid && tok.last_token;
  assign eof_ok    = tok.lexeme_len == 8'd0 && tok.token_kind == K_EOF;
  assign non_num   = tok_valid && tok.token_kind != K_NUMBER;
  assign num_zero  = tok.whole_value == '0 && !tok.is_real && !tok.overflow;

  `STT_ASSERT_NEXT(a_tok_hold, clk, rst, tok_stall, tok_valid && $stable(tok), "token not held")
  `STT_ASSERT_SAME(a_eof_len, clk, rst, tok_last, eof_ok, "bad end token")
  `STT_ASSERT_SAME(a_non_num, clk, rst, non_num, num_zero, "number fields on non-number")
  `STT_ASSERT_NEXT(a_empty_ready, clk, rst, !tok_valid && !src_fire, src_ready, "input blocked")

endmodule

bind source_text_tokenizer stt_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_ready (src_ready),
  .tok_valid (tok_valid),
  .tok_ready (tok_ready),
  .tok       (tok)
);

`default_nettype wire
